// ----- rtl/rau_pkg.sv -----
// Shared types, codes and defaults of the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

  // Default operand word width.
  localparam int WordBitsDef = 32;

  // Operation codes.
  localparam logic [2:0] OP_NORM = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_CMP  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Compare codes.
  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // Input word: operation and two fractions.
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         order;
    logic [1:0]         status;
  } rau_out_t;

endpackage

// ----- rtl/rau_stream_if.sv -----
// Valid/ready channel that carries one word of type T.
`timescale 1ns / 1ps

interface rau_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rau_reduce.sv -----
// Reduces a fraction of magnitudes by a binary gcd and two bit-serial divisions.
`timescale 1ns / 1ps

module rau_reduce
  import rau_pkg::*;
#(
  parameter int PW = 2 * WordBitsDef + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] num_i,
  input  logic [PW-1:0] den_i,
  output logic          done_o,
  output logic [PW-1:0] num_o,
  output logic [PW-1:0] den_o
);

  localparam int CW = $clog2(PW);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_GCD  = 2'd1;
  localparam logic [1:0] R_DIVN = 2'd2;
  localparam logic [1:0] R_DIVD = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] u_q, u_d, v_q, v_d, n_q, n_d, d_q, d_d;
  logic [PW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [PW:0]   shift_rem;
  logic [PW:0]   diff;
  logic          ge;

  // One restoring division step against the gcd held in v.
  assign shift_rem = {rem_q, quo_q[PW-1]};
  assign diff      = shift_rem - {1'b0, v_q};
  assign ge        = !diff[PW];

  // Sequencer: gcd steps first, then numerator and denominator quotients.
  always_comb begin
    state_d = state_q;
    u_d     = u_q;
    v_d     = v_q;
    n_d     = n_q;
    d_d     = d_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          u_d     = num_i;
          v_d     = den_i;
          n_d     = num_i;
          d_d     = den_i;
          state_d = R_GCD;
        end
      end
      R_GCD: begin
        if (u_q == '0) begin
          rem_d   = '0;
          quo_d   = n_q;
          cnt_d   = '0;
          state_d = R_DIVN;
        end else if (!u_q[0] && !v_q[0]) begin
          // Common factor two leaves the numbers and the gcd alike.
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          n_d = n_q >> 1;
          d_d = d_q >> 1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q >= v_q) begin
          u_d = u_q - v_q;
        end else begin
          v_d = v_q - u_q;
        end
      end
      R_DIVN, R_DIVD: begin
        rem_d = ge ? diff[PW-1:0] : shift_rem[PW-1:0];
        quo_d = {quo_q[PW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(PW - 1)) begin
          if (state_q == R_DIVN) begin
            n_d     = quo_d;
            rem_d   = '0;
            quo_d   = d_q;
            cnt_d   = '0;
            state_d = R_DIVD;
          end else begin
            d_d     = quo_d;
            done_d  = 1'b1;
            state_d = R_IDLE;
          end
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    n_q   <= n_d;
    d_q   <= d_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign num_o  = n_q;
  assign den_o  = d_q;

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit.
//
//   channel | dir | word      | meaning
//   in_i    | in  | rau_in_t  | operation and fractions A and B
//   out_o   | out | rau_out_t | reduced result, order and status
//
// One word at a time; in_i.ready is high only while no word is at work.
// A word takes up to three reductions (A, B and the result). Each is a binary gcd
// of one step per cycle, then two bit-serial divisions over 2*WORD_BITS+2 bits.
// A result reduction follows multiplier steps S_M1, S_M2 and, for sums, S_M3.
// A zero denominator ends a word at once, a zero divisor after the operands.
// Compares finish after the operands, S_M1 and S_M2, with no result reduction.
// A finished result waits in the output register; the next word may be taken.
// Reset is asynchronous and clears only control state.
`timescale 1ns / 1ps

module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rau_stream_if.sink            in_i,
  rau_stream_if.source          out_o
);

  localparam int MW = WORD_BITS + 1;
  localparam int PW = 2 * MW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_COMB = 4'd6;
  localparam logic [3:0] S_RR   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [PW-1:0] Half = PW'(1) << (WORD_BITS - 1);

  // Magnitude of a two's complement word read from its low bits.
  function automatic logic [MW-1:0] word_mag(input logic [31:0] raw);
    logic [MW-1:0] v;
    v = {1'b0, raw[WORD_BITS-1:0]};
    word_mag = raw[WORD_BITS-1] ? ((MW'(1) << WORD_BITS) - v) : v;
  endfunction

  logic [3:0]    state_q, state_d;
  rau_in_t       in_q;
  logic          an_q, bn_q, rneg_q;
  logic          an_d, bn_d, rneg_d;
  logic [MW-1:0] am_q, ad_q, bm_q, bd_q;
  logic [MW-1:0] am_d, ad_d, bm_d, bd_d;
  logic [PW-1:0] p1_q, p2_q, p3_q;
  logic [PW-1:0] p1_d, p2_d, p3_d;
  rau_out_t      rs_q, rs_d;
  rau_out_t      out_q;
  logic          ov_q;
  logic          load_out;

  logic          red_start, red_done;
  logic [PW-1:0] red_n, red_d, red_num, red_den;

  logic [MW-1:0] mx, my;
  logic [PW-1:0] prod;

  logic          s2;
  logic [PW-1:0] sum_mag;
  logic          sum_neg;
  logic          chk_neg;
  rau_out_t      chk;
  logic [WORD_BITS-1:0] num_w;

  logic          a_zero, b_zero;
  logic          in_take;

  assign in_take = in_i.valid && in_i.ready;
  assign a_zero  = in_i.data.a_den[WORD_BITS-1:0] == '0;
  assign b_zero  = in_i.data.b_den[WORD_BITS-1:0] == '0;

  rau_reduce #(.PW(PW)) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(red_start),
    .num_i  (red_n),
    .den_i  (red_d),
    .done_o (red_done),
    .num_o  (red_num),
    .den_o  (red_den)
  );

  // Shared multiplier; operand pair follows the step and the operation.
  always_comb begin
    mx = ad_q;
    my = (in_q.operation == OP_MUL) ? bd_q : bm_q;
    if (state_q == S_M1) begin
      mx = am_q;
      my = (in_q.operation == OP_MUL) ? bm_q : bd_q;
    end else if (state_q == S_M3) begin
      mx = ad_q;
      my = bd_q;
    end
  end
  assign prod = PW'(mx) * PW'(my);

  // Signed sum of the two cross products.
  always_comb begin
    s2 = (in_q.operation == OP_SUB) ? !bn_q : bn_q;
    if (an_q == s2) begin
      sum_neg = an_q;
      sum_mag = p1_q + p2_q;
    end else if (p1_q >= p2_q) begin
      sum_neg = an_q;
      sum_mag = p1_q - p2_q;
    end else begin
      sum_neg = s2;
      sum_mag = p2_q - p1_q;
    end
  end

  // Range check and packing of a reduced fraction.
  always_comb begin
    chk_neg = ((state_q == S_RA) ? an_q : rneg_q) && (red_num != '0);
    num_w   = chk_neg ? (WORD_BITS'(0) - red_num[WORD_BITS-1:0])
                      : red_num[WORD_BITS-1:0];
    chk     = '0;
    if ((chk_neg ? (red_num > Half) : (red_num >= Half)) || (red_den >= Half)) begin
      chk.status = ST_OVERFLOW;
    end else begin
      chk.res_num = 32'(signed'(num_w));
      chk.res_den = 31'(red_den[WORD_BITS-2:0]);
    end
  end

  assign load_out = (state_q == S_FIN) && (!ov_q || out_o.ready);

  // Operation sequencer.
  always_comb begin
    state_d   = state_q;
    an_d      = an_q;
    bn_d      = bn_q;
    rneg_d    = rneg_q;
    am_d      = am_q;
    ad_d      = ad_q;
    bm_d      = bm_q;
    bd_d      = bd_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    p3_d      = p3_q;
    rs_d      = rs_q;
    red_start = 1'b0;
    red_n     = PW'(word_mag(in_i.data.a_num));
    red_d     = PW'(word_mag(in_i.data.a_den));
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          rs_d = '0;
          an_d = in_i.data.a_num[WORD_BITS-1] ^ in_i.data.a_den[WORD_BITS-1];
          if (in_i.data.operation > OP_CMP) begin
            state_d = S_FIN;
          end else if (a_zero || (in_i.data.operation != OP_NORM && b_zero)) begin
            rs_d.status = ST_ZERO_DEN;
            state_d     = S_FIN;
          end else begin
            red_start = 1'b1;
            state_d   = S_RA;
          end
        end
      end
      S_RA: begin
        red_n = PW'(word_mag(in_q.b_num));
        red_d = PW'(word_mag(in_q.b_den));
        if (red_done) begin
          am_d = red_num[MW-1:0];
          ad_d = red_den[MW-1:0];
          an_d = an_q && (red_num != '0);
          bn_d = in_q.b_num[WORD_BITS-1] ^ in_q.b_den[WORD_BITS-1];
          if (in_q.operation == OP_NORM) begin
            rs_d    = chk;
            state_d = S_FIN;
          end else begin
            red_start = 1'b1;
            state_d   = S_RB;
          end
        end
      end
      S_RB: begin
        if (red_done) begin
          bm_d = red_num[MW-1:0];
          bd_d = red_den[MW-1:0];
          bn_d = bn_q && (red_num != '0);
          if (in_q.operation == OP_DIV && red_num == '0) begin
            rs_d.status = ST_DIV_ZERO;
            state_d     = S_FIN;
          end else begin
            state_d = S_M1;
          end
        end
      end
      S_M1: begin
        p1_d    = prod;
        state_d = S_M2;
      end
      S_M2: begin
        p2_d    = prod;
        state_d = (in_q.operation == OP_ADD || in_q.operation == OP_SUB) ? S_M3 : S_COMB;
      end
      S_M3: begin
        p3_d    = prod;
        state_d = S_COMB;
      end
      S_COMB: begin
        red_start = 1'b1;
        red_n     = p1_q;
        red_d     = p2_q;
        rneg_d    = an_q ^ bn_q;
        state_d   = S_RR;
        case (in_q.operation)
          OP_ADD, OP_SUB: begin
            red_n  = sum_mag;
            red_d  = p3_q;
            rneg_d = sum_neg;
          end
          OP_CMP: begin
            red_start = 1'b0;
            state_d   = S_FIN;
            if (p1_q == p2_q && an_q == bn_q) begin
              rs_d.order = ORD_EQUAL;
            end else if (an_q != bn_q) begin
              rs_d.order = an_q ? ORD_LESS : ORD_GREATER;
            end else if ((p1_q < p2_q) != an_q) begin
              rs_d.order = ORD_LESS;
            end else begin
              rs_d.order = ORD_GREATER;
            end
          end
          default: ;
        endcase
      end
      S_RR: begin
        if (red_done) begin
          rs_d    = chk;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i.data;
    end
    if (load_out) begin
      out_q <= rs_q;
    end
    an_q   <= an_d;
    bn_q   <= bn_d;
    rneg_q <= rneg_d;
    am_q   <= am_d;
    ad_q   <= ad_d;
    bm_q   <= bm_d;
    bd_q   <= bd_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    p3_q   <= p3_d;
    rs_q   <= rs_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

endmodule

// ----- rtl/rau_checker.sv -----
// Port-level checks of the rational arithmetic unit and their binding.
`timescale 1ns / 1ps

module rau_checker
  import rau_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input rau_out_t out_data_i
);

  // A pending result word stays until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word dropped or changed while stalled");

  // The unit is not ready again in the cycle after it takes a word.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken twice in a row");

  // Error results carry no fraction and no order.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != ST_OK |->
      out_data_i.res_num == '0 && out_data_i.res_den == '0 && out_data_i.order == ORD_LESS)
    else $error("error result with nonzero fields");

  // A nonzero order only comes from a clean compare.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.order != ORD_LESS |->
      out_data_i.status == ST_OK && out_data_i.res_den == '0 && out_data_i.res_num == '0)
    else $error("order set outside compare");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
